/* rtl/rnlu_pkg.sv */
// Shared types and constants for the range normalize / linear upsampler.
// No dependencies.
package rnlu_pkg;

    localparam int RANGE_W    = 16;
    localparam int FACTOR_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = RANGE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [FACTOR_W:0]  MAX_FACTOR        = 7'd63;
    localparam logic [RANGE_W-1:0] REPLACE_OFFSET_MM = 16'd100;

    localparam logic [RANGE_W-1:0]  RANGE_MIN_RESET = 16'd20;
    localparam logic [RANGE_W-1:0]  RANGE_MAX_RESET = 16'd5600;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET    = 6'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMMIT,
        ST_DIV_INIT,
        ST_DIV,
        ST_EMIT,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic emit_interp;
        logic emit_last;
        logic emit_final;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic                have_prev;
        logic                eos;
        logic                out_free;
        logic [FACTOR_W-1:0] factor;
    } status_t;

endpackage

/* rtl/rnlu_ctrl.sv */
// Controller state machine for the range upsampler.
// Depends on rnlu_pkg; drives commands to rnlu_datapath.
module rnlu_ctrl
    import rnlu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [FACTOR_W-1:0]  j_reg, j_next;
    logic                 div_done;
    logic                 j_last;

    assign div_done = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign j_last   = (j_reg == (status.factor - FACTOR_W'(1)));
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.have_prev)
                begin
                    state_next = ST_DIV_INIT;
                end
                else if (status.eos)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && j_last)
                begin
                    state_next = status.eos ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        div_cnt_next = div_cnt_reg;
        j_next       = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_COMMIT:
            begin
                // first sample with no history and no end of scan: just store it
                cmd.commit = !status.have_prev && !status.eos;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                j_next       = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_interp = 1'b1;
                    cmd.emit_last   = j_last && !status.eos;
                    cmd.commit      = j_last && !status.eos;
                    j_next          = j_reg + FACTOR_W'(1);
                end
            end
            ST_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    cmd.commit     = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            j_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            j_reg       <= j_next;
        end
    end

endmodule

/* rtl/rnlu_datapath.sv */
// Datapath: config registers, normalizer, history, radix-2 divider,
// quotient/remainder accumulators and output register. Depends on rnlu_pkg.
module rnlu_datapath
    import rnlu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANGE_W-1:0]   cfg_data,
    input  logic [RANGE_W-1:0]   range_mm,
    input  logic                 invalid,
    input  logic                 end_of_scan,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [RANGE_W-1:0]   sample_mm,
    output logic                 last_of_run,
    output logic                 scan_done,
    input  cmd_t                 cmd,
    output status_t              status
);

    logic [RANGE_W-1:0]  range_min_reg, range_max_reg;
    logic [FACTOR_W-1:0] factor_cfg_reg;
    logic [FACTOR_W-1:0] factor_eff;

    logic [RANGE_W-1:0]  cur_reg, prev_reg;
    logic                eos_reg, have_prev_reg;
    logic                neg_reg;
    logic [RANGE_W-1:0]  dvd_reg;
    logic [FACTOR_W-1:0] rem_reg;
    logic [RANGE_W-1:0]  q_reg;
    logic [FACTOR_W-1:0] racc_reg;

    logic                out_valid_reg;
    logic [RANGE_W-1:0]  sample_reg;
    logic                last_reg, done_reg;

    logic [RANGE_W-1:0]  repl;
    logic [RANGE_W-1:0]  norm;
    logic [RANGE_W-1:0]  abs_diff;
    logic [FACTOR_W:0]   rem_shift;
    logic                qbit;
    logic [FACTOR_W:0]   racc_sum;
    logic                racc_wrap;
    logic [RANGE_W-1:0]  interp;
    logic                out_free;

    always_comb
    begin
        factor_eff = factor_cfg_reg;
        if (factor_cfg_reg == '0)
        begin
            factor_eff = FACTOR_W'(1);
        end
        else if ({1'b0, factor_cfg_reg} > MAX_FACTOR)
        begin
            factor_eff = MAX_FACTOR[FACTOR_W-1:0];
        end
    end

    assign repl = (range_max_reg >= REPLACE_OFFSET_MM) ? (range_max_reg - REPLACE_OFFSET_MM) : '0;
    assign norm = (invalid || (range_mm > range_max_reg) || (range_mm < range_min_reg))
                  ? repl : range_mm;

    assign abs_diff = (cur_reg >= prev_reg) ? (cur_reg - prev_reg) : (prev_reg - cur_reg);

    assign rem_shift = {rem_reg, dvd_reg[RANGE_W-1]};
    assign qbit      = (rem_shift >= {1'b0, factor_eff});

    assign racc_sum  = {1'b0, racc_reg} + {1'b0, rem_reg};
    assign racc_wrap = (racc_sum >= {1'b0, factor_eff});

    assign interp   = neg_reg ? (prev_reg - q_reg) : (prev_reg + q_reg);
    assign out_free = !out_valid_reg || !out_stall;

    assign status.have_prev = have_prev_reg;
    assign status.eos       = eos_reg;
    assign status.out_free  = out_free;
    assign status.factor    = factor_eff;

    assign out_valid   = out_valid_reg;
    assign sample_mm   = sample_reg;
    assign last_of_run = last_reg;
    assign scan_done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg  <= RANGE_MIN_RESET;
            range_max_reg  <= RANGE_MAX_RESET;
            factor_cfg_reg <= FACTOR_RESET;
            prev_reg       <= '0;
            have_prev_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RANGE_MIN: range_min_reg  <= cfg_data;
                    CFG_RANGE_MAX: range_max_reg  <= cfg_data;
                    CFG_FACTOR:    factor_cfg_reg <= cfg_data[FACTOR_W-1:0];
                    default:       ;
                endcase
            end
            if (cmd.commit)
            begin
                prev_reg      <= eos_reg ? '0 : cur_reg;
                have_prev_reg <= !eos_reg;
            end
            if (cmd.emit_interp || cmd.emit_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= norm;
            eos_reg <= end_of_scan;
        end
        if (cmd.div_init)
        begin
            neg_reg  <= (cur_reg < prev_reg);
            dvd_reg  <= abs_diff;
            rem_reg  <= '0;
            q_reg    <= '0;
            racc_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? FACTOR_W'(rem_shift - {1'b0, factor_eff}) : rem_shift[FACTOR_W-1:0];
            dvd_reg <= {dvd_reg[RANGE_W-2:0], qbit};
        end
        if (cmd.emit_interp)
        begin
            sample_reg <= interp;
            last_reg   <= cmd.emit_last;
            done_reg   <= 1'b0;
            q_reg      <= q_reg + dvd_reg + RANGE_W'(racc_wrap);
            racc_reg   <= racc_wrap ? FACTOR_W'(racc_sum - {1'b0, factor_eff})
                                    : racc_sum[FACTOR_W-1:0];
        end
        if (cmd.emit_final)
        begin
            sample_reg <= cur_reg;
            last_reg   <= 1'b1;
            done_reg   <= 1'b1;
        end
    end

endmodule

/* rtl/range_normalize_linear_upsampler_core.sv */
// Range normalize and linear upsampler, top level.
// A sample with history runs a 16-step divider on the segment delta before the
// first of F results (F = effective factor), then emits one result per cycle
// while out_stall permits; at end of scan a final result follows. A first
// sample of a scan only stores its value unless it ends the scan. in_stall
// holds off the next sample until the current one is done. Reset: history
// cleared, registers at defaults (min 20, max 5600, factor 20). Depends on rnlu_pkg.
module range_normalize_linear_upsampler_core
    import rnlu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANGE_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [RANGE_W-1:0]   range_mm,
    input  logic                 invalid,
    input  logic                 end_of_scan,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [RANGE_W-1:0]   sample_mm,
    output logic                 last_of_run,
    output logic                 scan_done
);

    cmd_t    cmd;
    status_t status;

    rnlu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rnlu_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .range_mm    (range_mm),
        .invalid     (invalid),
        .end_of_scan (end_of_scan),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_mm   (sample_mm),
        .last_of_run (last_of_run),
        .scan_done   (scan_done),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
